### hw/rtl/complex_similarity_blend_assert.svh
// Assertion macros shared by the RTL.
`ifndef COMPLEX_SIMILARITY_BLEND_ASSERT_SVH
`define COMPLEX_SIMILARITY_BLEND_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define CPXS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define CPXS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/cpxs_pkg.sv
`default_nettype none
package cpxs_pkg;
   localparam int MAX_N_DEF = 8;
   localparam int ELEM_W    = 16;
   localparam int T_W       = 24;
   localparam int RES_W     = 40;
   localparam int SIZE_W    = 4;
   localparam int COEF_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W_DEF = 41 + $clog2(MAX_N_DEF);

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PRODUCT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BLEND   = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET    = 4'd8;
   localparam logic [COEF_W-1:0] PRODUCT_RESET = 16'd20252;
   localparam logic [COEF_W-1:0] BLEND_RESET   = 16'd12516;
   localparam logic [RES_W-1:0]  RES_MAX       = {RES_W{1'b1}};

   typedef struct packed {
      logic signed [ELEM_W-1:0] u_real;
      logic signed [ELEM_W-1:0] u_imag;
      logic signed [ELEM_W-1:0] rho_real;
      logic signed [ELEM_W-1:0] rho_imag;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] s_real;
      logic signed [ELEM_W-1:0] s_imag;
      logic                     last_element;
      logic [RES_W-1:0]         residual;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic first;
      logic conj;
   } mac_ctl_type;

   typedef struct packed {
      logic start;
      logic clear;
   } post_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } post_sts_type;
endpackage
`default_nettype wire

### hw/rtl/cpxs_cmac.sv
`default_nettype none
// Shared complex multiply-accumulate, optional conjugate on y.
module cpxs_cmac import cpxs_pkg::*; #(
   parameter int ACC_W = ACC_W_DEF
) (
   input  wire logic                     clock,
   input  wire mac_ctl_type              ctl,
   input  wire logic signed [T_W-1:0]    x_re,
   input  wire logic signed [T_W-1:0]    x_im,
   input  wire logic signed [ELEM_W-1:0] y_re,
   input  wire logic signed [ELEM_W-1:0] y_im,
   output logic signed [ACC_W-1:0]       acc_re,
   output logic signed [ACC_W-1:0]       acc_im
);
   localparam int P_W = T_W + ELEM_W + 1;

   logic signed [P_W-1:0]   rr, ii, ri, ir;
   logic signed [P_W-1:0]   sum_re, sum_im;
   logic signed [ACC_W-1:0] re_ff, im_ff, re_in, im_in;

   always_comb begin
      rr = P_W'(x_re) * P_W'(y_re);
      ii = P_W'(x_im) * P_W'(y_im);
      ri = P_W'(x_re) * P_W'(y_im);
      ir = P_W'(x_im) * P_W'(y_re);
      sum_re = ctl.conj ? rr + ii : rr - ii;
      sum_im = ctl.conj ? ir - ri : ri + ir;
      re_in = ctl.first ? ACC_W'(sum_re) : re_ff + ACC_W'(sum_re);
      im_in = ctl.first ? ACC_W'(sum_im) : im_ff + ACC_W'(sum_im);
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign acc_re = re_ff;
   assign acc_im = im_ff;
endmodule
`default_nettype wire

### hw/rtl/cpxs_post.sv
`default_nettype none
// Scale, blend, round and residual: one 17x25 multiplier over nine steps.
module cpxs_post import cpxs_pkg::*; #(
   parameter int ACC_W = ACC_W_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire post_ctl_type             ctl,
   input  wire logic signed [ACC_W-1:0]  p_re,
   input  wire logic signed [ACC_W-1:0]  p_im,
   input  wire logic signed [ELEM_W-1:0] rho_re,
   input  wire logic signed [ELEM_W-1:0] rho_im,
   input  wire logic [COEF_W-1:0]        coef_a,
   input  wire logic [COEF_W-1:0]        coef_b,
   output post_sts_type                  sts,
   output logic signed [ELEM_W-1:0]      s_re,
   output logic signed [ELEM_W-1:0]      s_im,
   output logic [RES_W-1:0]              resid
);
   localparam int SUM_W = ACC_W + 18;
   localparam int OP_W  = 25;
   localparam int PR_W  = OP_W + 17;
   localparam logic [3:0] LAST_STEP = 4'd8;
   localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) << 26;
   localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(32767);
   localparam logic signed [SUM_W-1:0] S_MIN = -SUM_W'(32768);

   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [3:0]               step_ff, step_in;
   logic signed [ACC_W-1:0]  pr_ff, pi_ff;
   logic signed [ELEM_W-1:0] rr_ff, ri_ff;
   logic signed [SUM_W-1:0]  ar_ff, ai_ff, ar_in, ai_in;
   logic signed [ELEM_W-1:0] sr_ff, si_ff, sr_in, si_in;
   logic signed [16:0]       dr_ff, di_ff, dr_in, di_in;
   logic [RES_W-1:0]         res_ff, res_in;
   logic signed [16:0]       op_a;
   logic signed [OP_W-1:0]   op_b;
   logic signed [PR_W-1:0]   prod;
   logic signed [SUM_W-1:0]  pext, rnd_r, rnd_i;
   logic [RES_W:0]           rsum;

   function automatic logic signed [ELEM_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] q;
      q = v >>> 27;
      if (q > S_MAX) return ELEM_W'(S_MAX);
      if (q < S_MIN) return ELEM_W'(S_MIN);
      return ELEM_W'(q);
   endfunction

   always_comb begin
      op_a = $signed({1'b0, coef_a});
      op_b = '0;
      case (step_ff)
         4'd0: op_b = $signed({1'b0, pr_ff[23:0]});
         4'd1: op_b = OP_W'(pr_ff >>> 24);
         4'd2: begin op_a = $signed({1'b0, coef_b}); op_b = OP_W'(rr_ff); end
         4'd3: op_b = $signed({1'b0, pi_ff[23:0]});
         4'd4: op_b = OP_W'(pi_ff >>> 24);
         4'd5: begin op_a = $signed({1'b0, coef_b}); op_b = OP_W'(ri_ff); end
         4'd7: begin op_a = dr_ff; op_b = OP_W'(dr_ff); end
         4'd8: begin op_a = di_ff; op_b = OP_W'(di_ff); end
         default: op_b = '0;
      endcase
      prod = op_a * op_b;
      pext = SUM_W'(prod);
      rnd_r = ar_ff + HALF;
      rnd_i = ai_ff + HALF;
      rsum = {1'b0, res_ff} + prod[RES_W:0];

      ar_in = ar_ff;
      ai_in = ai_ff;
      sr_in = sr_ff;
      si_in = si_ff;
      dr_in = dr_ff;
      di_in = di_ff;
      res_in = res_ff;
      case (step_ff)
         4'd0: ar_in = pext;
         4'd1: ar_in = ar_ff + (pext <<< 24);
         4'd2: ar_in = ar_ff + (pext <<< 12);
         4'd3: ai_in = pext;
         4'd4: ai_in = ai_ff + (pext <<< 24);
         4'd5: ai_in = ai_ff + (pext <<< 12);
         4'd6: begin
            sr_in = sat16(rnd_r);
            si_in = sat16(rnd_i);
            dr_in = $signed({sr_in[15], sr_in}) - $signed({rr_ff[15], rr_ff});
            di_in = $signed({si_in[15], si_in}) - $signed({ri_ff[15], ri_ff});
         end
         4'd7, 4'd8: res_in = (rsum > {1'b0, RES_MAX}) ? RES_MAX : rsum[RES_W-1:0];
         default: res_in = res_ff;
      endcase

      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         res_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         if (ctl.start && ctl.clear) res_ff <= '0;
         else if (busy_ff) res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         pr_ff <= p_re;
         pi_ff <= p_im;
         rr_ff <= rho_re;
         ri_ff <= rho_im;
      end else if (busy_ff) begin
         ar_ff <= ar_in;
         ai_ff <= ai_in;
         sr_ff <= sr_in;
         si_ff <= si_in;
         dr_ff <= dr_in;
         di_ff <= di_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign s_re  = sr_ff;
   assign s_im  = si_ff;
   assign resid = res_ff;
endmodule
`default_nettype wire

### hw/rtl/complex_similarity_blend.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_type: one U element, one rho element
// rsp      out        rsp_valid/rsp_ready  rsp_type: one S element, last flag, residual
// csr      in         csr_valid/csr_ready  csr_index, csr_data (always ready)
//
// Loading takes one item per cycle while the sequencer is idle. The item
// that completes an n*n matrix starts the compute: T = U*rho runs on the
// shared complex MAC, then each S element takes n MAC terms, a drain, the
// start, nine steps of the scaling multiplier and the output load.
// Reset (synchronous) clears control, size/coefficients and load count;
// stores are not cleared. A stalled rsp holds the sequencer at the output
// step; after the last element the block takes new items while it waits.
module complex_similarity_blend import cpxs_pkg::*; #(
   parameter int MAX_N = MAX_N_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COEF_W-1:0]    csr_data
);
   `include "complex_similarity_blend_assert.svh"

   localparam int DEPTH = MAX_N * MAX_N;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LC_W  = $clog2(DEPTH + 1);
   localparam int CNT_W = $clog2(MAX_N + 1);
   localparam int ACC_W = 41 + $clog2(MAX_N);
   localparam logic signed [ACC_W-1:0] T_HALF = ACC_W'(2048);
   localparam logic signed [ACC_W-1:0] T_HI   = ACC_W'(8388607);
   localparam logic signed [ACC_W-1:0] T_LO   = -ACC_W'(8388608);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_T_RUN   = 3'd1;
   localparam logic [2:0] S_T_DRAIN = 3'd2;
   localparam logic [2:0] S_T_WR    = 3'd3;
   localparam logic [2:0] S_P_RUN   = 3'd4;
   localparam logic [2:0] S_P_DRAIN = 3'd5;
   localparam logic [2:0] S_P_START = 3'd6;
   localparam logic [2:0] S_P_WAIT  = 3'd7;

   // configuration
   logic [SIZE_W-1:0] size_ff;
   logic [COEF_W-1:0] coef_a_ff, coef_b_ff;

   // control
   logic [2:0]       state_ff, state_in;
   logic             out_step_ff, out_step_in;   // output step within S_P_WAIT
   logic [LC_W-1:0]  lc_ff, lc_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             issue_ff, issue_in, first_ff, first_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // stores: real part in the low half
   logic [2*ELEM_W-1:0] u_mem   [DEPTH];
   logic [2*ELEM_W-1:0] rho_mem [DEPTH];
   logic [2*T_W-1:0]    t_mem   [DEPTH];
   logic [2*ELEM_W-1:0] u_rd_ff, rho_rd_ff;
   logic [2*T_W-1:0]    t_rd_ff;
   logic [IDX_W-1:0]    u_addr, rho_addr, t_addr, t_waddr;
   logic                load_we, t_we;
   logic [2*T_W-1:0]    t_wdata;

   logic [CNT_W-1:0]  n_w;
   logic [LC_W-1:0]   nn_w;
   logic              k_last, j_last, i_last, p_phase, can_load;
   mac_ctl_type       mac_ctl;
   post_ctl_type      post_ctl;
   post_sts_type      post_sts;
   logic signed [ACC_W-1:0]  acc_re, acc_im;
   logic signed [T_W-1:0]    x_re, x_im;
   logic signed [ELEM_W-1:0] y_re, y_im, s_re, s_im;
   logic [RES_W-1:0]         resid;

   function automatic logic [IDX_W-1:0] idx(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c,
                                            input logic [CNT_W-1:0] n);
      logic [2*CNT_W-1:0] v;
      v = r * n + (2*CNT_W)'(c);
      return v[IDX_W-1:0];
   endfunction

   function automatic logic signed [T_W-1:0] t_round(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] q;
      q = (a + T_HALF) >>> 12;
      if (q > T_HI) return T_W'(T_HI);
      if (q < T_LO) return T_W'(T_LO);
      return T_W'(q);
   endfunction

   // configuration port, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RESET;
         coef_a_ff <= PRODUCT_RESET;
         coef_b_ff <= BLEND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MATRIX_SIZE:  size_ff   <= csr_data[SIZE_W-1:0];
            CSR_COEF_PRODUCT: coef_a_ff <= csr_data;
            CSR_COEF_BLEND:   coef_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // size clamped to 1..MAX_N
   always_comb begin
      if (size_ff == '0) n_w = CNT_W'(1);
      else if ({1'b0, size_ff} > (SIZE_W+1)'(MAX_N)) n_w = CNT_W'(MAX_N);
      else n_w = CNT_W'(size_ff);
      nn_w = LC_W'(n_w) * LC_W'(n_w);
   end

   assign k_last  = (k_ff == n_w - CNT_W'(1));
   assign j_last  = (j_ff == n_w - CNT_W'(1));
   assign i_last  = (i_ff == n_w - CNT_W'(1));
   assign p_phase = (state_ff == S_P_RUN) || (state_ff == S_P_DRAIN);
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign load_we = req_valid && req_ready && (lc_ff < LC_W'(DEPTH));
   assign t_we    = (state_ff == S_T_WR);
   assign t_waddr = idx(i_ff, j_ff, n_w);
   assign t_wdata = {t_round(acc_im), t_round(acc_re)};

   // read addresses: T phase walks U rows and rho columns,
   // P phase walks T rows and U rows (for U^H)
   always_comb begin
      u_addr   = p_phase ? idx(j_ff, k_ff, n_w) : idx(i_ff, k_ff, n_w);
      rho_addr = (state_ff == S_P_DRAIN) ? idx(i_ff, j_ff, n_w) : idx(k_ff, j_ff, n_w);
      t_addr   = idx(i_ff, k_ff, n_w);
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         u_mem[lc_ff[IDX_W-1:0]]   <= {req_payload.u_imag, req_payload.u_real};
         rho_mem[lc_ff[IDX_W-1:0]] <= {req_payload.rho_imag, req_payload.rho_real};
      end
      if (t_we) t_mem[t_waddr] <= t_wdata;
      u_rd_ff   <= u_mem[u_addr];
      rho_rd_ff <= rho_mem[rho_addr];
      t_rd_ff   <= t_mem[t_addr];
   end

   // MAC operands: x is U (T phase) or T (P phase, y conjugated)
   always_comb begin
      if (p_phase) begin
         x_re = $signed(t_rd_ff[T_W-1:0]);
         x_im = $signed(t_rd_ff[2*T_W-1:T_W]);
         y_re = $signed(u_rd_ff[ELEM_W-1:0]);
         y_im = $signed(u_rd_ff[2*ELEM_W-1:ELEM_W]);
      end else begin
         x_re = T_W'($signed(u_rd_ff[ELEM_W-1:0]));
         x_im = T_W'($signed(u_rd_ff[2*ELEM_W-1:ELEM_W]));
         y_re = $signed(rho_rd_ff[ELEM_W-1:0]);
         y_im = $signed(rho_rd_ff[2*ELEM_W-1:ELEM_W]);
      end
      mac_ctl.en    = issue_ff;
      mac_ctl.first = first_ff;
      mac_ctl.conj  = p_phase;
   end

   cpxs_cmac #(.ACC_W(ACC_W)) u_cmac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .x_re   (x_re),
      .x_im   (x_im),
      .y_re   (y_re),
      .y_im   (y_im),
      .acc_re (acc_re),
      .acc_im (acc_im)
   );

   assign post_ctl.start = (state_ff == S_P_START);
   assign post_ctl.clear = (i_ff == '0) && (j_ff == '0);

   cpxs_post #(.ACC_W(ACC_W)) u_post (
      .clock  (clock),
      .reset  (reset),
      .ctl    (post_ctl),
      .p_re   (acc_re),
      .p_im   (acc_im),
      .rho_re ($signed(rho_rd_ff[ELEM_W-1:0])),
      .rho_im ($signed(rho_rd_ff[2*ELEM_W-1:ELEM_W])),
      .coef_a (coef_a_ff),
      .coef_b (coef_b_ff),
      .sts    (post_sts),
      .s_re   (s_re),
      .s_im   (s_im),
      .resid  (resid)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      out_step_in  = out_step_ff;
      lc_in        = lc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      issue_in     = 1'b0;
      first_in     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (lc_ff + LC_W'(1) >= nn_w) begin
                  lc_in    = '0;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = S_T_RUN;
               end else begin
                  lc_in = lc_ff + LC_W'(1);
               end
            end
         end
         S_T_RUN, S_P_RUN: begin
            issue_in = 1'b1;
            first_in = (k_ff == '0);
            if (k_last) begin
               k_in     = '0;
               state_in = (state_ff == S_T_RUN) ? S_T_DRAIN : S_P_DRAIN;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         S_T_DRAIN: state_in = S_T_WR;
         S_T_WR: begin
            state_in = S_T_RUN;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  i_in     = '0;
                  state_in = S_P_RUN;
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         S_P_DRAIN: state_in = S_P_START;
         S_P_START: begin
            out_step_in = 1'b0;
            state_in    = S_P_WAIT;
         end
         S_P_WAIT: begin
            // wait for the scaler, then for a free output register
            if (post_sts.done) out_step_in = 1'b1;
            if ((out_step_ff || post_sts.done) && can_load) begin
               out_step_in  = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in.s_real = s_re;
               rsp_in.s_imag = s_im;
               rsp_in.last_element = i_last && j_last;
               rsp_in.residual = (i_last && j_last) ? resid : '0;
               state_in = S_P_RUN;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     i_in     = '0;
                     state_in = S_IDLE;
                  end else begin
                     i_in = i_ff + CNT_W'(1);
                  end
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_step_ff  <= 1'b0;
         lc_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         issue_ff     <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_step_ff  <= out_step_in;
         lc_ff        <= lc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         issue_ff     <= issue_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks; a size write mid-load can leave the count above n*n
   `CPXS_ASSERT_SAME(a_done_in_wait, clock, reset, post_sts.done, state_ff == S_P_WAIT)
   `CPXS_ASSERT_SAME(a_resid_on_last, clock, reset,
      rsp_valid_ff && !rsp_ff.last_element, rsp_ff.residual == '0)
   `CPXS_ASSERT_SAME(a_load_bound, clock, reset, state_ff == S_IDLE, lc_ff < LC_W'(DEPTH))
   `CPXS_ASSERT_NEXT(a_start_busy, clock, reset, state_ff == S_P_START, post_sts.busy)
endmodule
`default_nettype wire
